@@ src/a85_pkg.sv @@
// ============================================================================
// a85_pkg
// Shared types, character codes and small tables for the ASCII85 decoder.
// ============================================================================
package a85_pkg;

    // Default number of result bursts the output queue can hold.
    localparam int A85_QUEUE_DEPTH = 2;

    localparam logic [6:0]  A85_BASE    = 7'd85;
    localparam logic [31:0] A85_PAD_ADD = 32'h00FF_FFFF;

    localparam logic [7:0] CH_FIRST = 8'h21;  // '!'
    localparam logic [7:0] CH_LAST  = 8'h75;  // 'u'
    localparam logic [7:0] CH_ZERO  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // All results caused by one input word: up to four data bytes taken
    // from the top of data_word, then an optional final result.
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  ndata;
        logic        has_final;
        logic [1:0]  final_status;
    } burst_t;

    // Scale applied to a partial group so that it reaches five digits.
    function automatic logic [19:0] a85_tail_scale(input logic [2:0] cnt);
        logic [19:0] s;
        case (cnt)
            3'd2:    s = 20'd614125;
            3'd3:    s = 20'd7225;
            3'd4:    s = 20'd85;
            default: s = 20'd1;
        endcase
        return s;
    endfunction

    // Padding added to a scaled partial group.
    function automatic logic [31:0] a85_tail_pad(input logic [2:0] cnt);
        logic [31:0] p;
        case (cnt)
            3'd2:    p = A85_PAD_ADD;
            3'd3:    p = A85_PAD_ADD >> 8;
            3'd4:    p = A85_PAD_ADD >> 16;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

@@ src/a85_out_queue.sv @@
// ============================================================================
// a85_out_queue
// Holds result bursts and hands them out one result word per cycle while out_ready is high.
// ============================================================================
module a85_out_queue #(
    parameter int DEPTH = a85_pkg::A85_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  a85_pkg::burst_t    push_burst,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output a85_pkg::out_item_t out_data
);
    import a85_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    burst_t          entry_reg [DEPTH];
    logic [PtrW-1:0] head_reg;
    logic [PtrW-1:0] head_next;
    logic [PtrW-1:0] tail_reg;
    logic [PtrW-1:0] tail_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic [2:0]      pos_reg;
    logic [2:0]      pos_next;

    burst_t     head_burst;
    logic [2:0] total;
    logic       pop;
    logic       take;

    assign head_burst = entry_reg[head_reg];
    assign total      = head_burst.ndata + {2'b00, head_burst.has_final};
    assign out_valid  = (count_reg != '0);
    assign full       = (count_reg == CntW'(DEPTH));
    assign take       = out_valid && out_ready;
    assign pop        = take && (pos_reg == total - 3'd1);

    always_comb
    begin
        if (pos_reg < head_burst.ndata)
        begin
            case (pos_reg[1:0])
                2'd0:    out_data.out_byte = head_burst.data_word[31:24];
                2'd1:    out_data.out_byte = head_burst.data_word[23:16];
                2'd2:    out_data.out_byte = head_burst.data_word[15:8];
                default: out_data.out_byte = head_burst.data_word[7:0];
            endcase
            out_data.status = ST_DATA;
            out_data.last   = 1'b0;
        end
        else
        begin
            out_data.out_byte = 8'd0;
            out_data.status   = head_burst.final_status;
            out_data.last     = 1'b1;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (take)
        begin
            pos_next = pop ? 3'd0 : pos_reg + 3'd1;
        end
        if (pop)
        begin
            head_next = (head_reg == PtrW'(DEPTH - 1)) ? '0 : head_reg + PtrW'(1);
        end
        if (push)
        begin
            tail_next = (tail_reg == PtrW'(DEPTH - 1)) ? '0 : tail_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_burst;
        end
    end

    // A burst with no results must never occupy a slot.
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_burst.ndata != 3'd0 || push_burst.has_final))
        else $error("empty burst pushed");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into a full queue");

    a_pos_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_reg < total)
        else $error("result index past end of burst");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && out_data.last) |-> pop)
        else $error("final result did not retire its burst");

endmodule

@@ src/ascii85_stream_decoder.sv @@
// ============================================================================
// ascii85_stream_decoder
// ASCII85 decoder taking one character per word and producing decoded bytes.
// ============================================================================
// Usage:
//   The input channel takes one character word per cycle, with end_of_buffer
//   marking the last character of an encoded buffer. The output channel gives
//   one result word per cycle while out_ready is high: a data byte (status 0),
//   an end-of-stream word (status 1) or a format error (status 2); last is set
//   on the end and error words. A character can cause up to five result words.
//   Results of a character accepted at a clock edge are written into the
//   output queue at that edge. Input throughput is one character per cycle
//   as long as the output queue has a free slot; while out_ready is high the
//   output side drains one result per cycle, so a stream of full groups
//   (five characters for four bytes) runs at full rate.
//   The group arithmetic is one 32 by 20 bit multiply and an add between the
//   group register and the output queue.
//   Reset clears the group state and empties the queue. When the receiver
//   stalls, pending results stay in the queue; once it is full, in_ready
//   drops until a burst has been delivered.
// ============================================================================
module ascii85_stream_decoder #(
    parameter int QUEUE_DEPTH = a85_pkg::A85_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  a85_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output a85_pkg::out_item_t out_data
);
    import a85_pkg::*;

    logic [31:0] group_value_reg;
    logic [31:0] group_value_next;
    logic [2:0]  group_count_reg;
    logic [2:0]  group_count_next;
    logic        tilde_pending_reg;
    logic        tilde_pending_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic        queue_full;
    logic        accept;
    logic        push;
    burst_t      burst;

    logic [7:0]  c;
    logic        eob;
    logic        fin;
    logic [19:0] factor;
    logic [31:0] mul_lo;
    logic [7:0]  digit;
    logic [2:0]  count_inc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (burst.ndata != 3'd0 || burst.has_final);

    always_comb
    begin
        c   = in_data.in_char;
        eob = in_data.end_of_buffer;
        fin = 1'b0;

        group_value_next   = group_value_reg;
        group_count_next   = group_count_reg;
        tilde_pending_next = tilde_pending_reg;
        stopped_next       = stopped_reg;
        burst              = '0;

        // One shared multiplier: by 85 for a new digit, by 85^k for a tail.
        factor    = tilde_pending_reg ? a85_tail_scale(group_count_reg)
                                      : {13'd0, A85_BASE};
        mul_lo    = group_value_reg * {12'd0, factor};
        digit     = c - CH_FIRST;
        count_inc = group_count_reg + 3'd1;

        if (stopped_reg)
        begin
            if (eob)
            begin
                group_value_next   = 32'd0;
                group_count_next   = 3'd0;
                tilde_pending_next = 1'b0;
                stopped_next       = 1'b0;
            end
        end
        else
        begin
            if (tilde_pending_reg)
            begin
                tilde_pending_next = 1'b0;
                fin                = 1'b1;
                burst.has_final    = 1'b1;
                if (c == CH_GT && group_count_reg != 3'd1)
                begin
                    burst.final_status = ST_END;
                    if (group_count_reg >= 3'd2)
                    begin
                        burst.ndata     = group_count_reg - 3'd1;
                        burst.data_word = mul_lo + a85_tail_pad(group_count_reg);
                    end
                end
                else
                begin
                    burst.final_status = ST_ERR;
                end
            end
            else if (c inside {[CH_FIRST:CH_LAST]})
            begin
                if (count_inc == 3'd5)
                begin
                    burst.ndata      = 3'd4;
                    burst.data_word  = mul_lo + {24'd0, digit};
                    group_value_next = 32'd0;
                    group_count_next = 3'd0;
                end
                else
                begin
                    group_value_next = mul_lo + {24'd0, digit};
                    group_count_next = count_inc;
                end
            end
            else if (c == CH_ZERO)
            begin
                if (group_count_reg != 3'd0)
                begin
                    fin                = 1'b1;
                    burst.has_final    = 1'b1;
                    burst.final_status = ST_ERR;
                end
                else
                begin
                    burst.ndata = 3'd4;
                end
            end
            else if (c == CH_TILDE)
            begin
                if (eob)
                begin
                    fin                = 1'b1;
                    burst.has_final    = 1'b1;
                    burst.final_status = ST_ERR;
                end
                else
                begin
                    tilde_pending_next = 1'b1;
                end
            end
            else if (!(c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}))
            begin
                fin                = 1'b1;
                burst.has_final    = 1'b1;
                burst.final_status = ST_ERR;
            end

            if (fin)
            begin
                group_value_next   = 32'd0;
                group_count_next   = 3'd0;
                tilde_pending_next = 1'b0;
                stopped_next       = !eob;
            end
            else if (eob)
            begin
                // A partial group left at the end of the buffer is dropped.
                burst.has_final    = 1'b1;
                burst.final_status = ST_END;
                group_value_next   = 32'd0;
                group_count_next   = 3'd0;
                tilde_pending_next = 1'b0;
                stopped_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_value_reg   <= 32'd0;
            group_count_reg   <= 3'd0;
            tilde_pending_reg <= 1'b0;
            stopped_reg       <= 1'b0;
        end
        else if (accept)
        begin
            group_value_reg   <= group_value_next;
            group_count_reg   <= group_count_next;
            tilde_pending_reg <= tilde_pending_next;
            stopped_reg       <= stopped_next;
        end
    end

    a85_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_burst (burst),
        .full       (queue_full),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        group_count_reg <= 3'd4)
        else $error("group count out of range");

    a_stopped_clean: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (group_count_reg == 3'd0 && !tilde_pending_reg))
        else $error("group state left behind after a final result");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stopped_reg) |-> !push)
        else $error("result produced while stopped");

endmodule
